// File: hdl/epr_pkg.sv
// Shared types, constants and tables for the Euler point rotator.
package epr_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int ANGLE_WIDTH_DEF = 16;
   localparam int TRIG_FRAC_DEF   = 16;

   localparam int MAT_FRAC     = 30;
   localparam int ENTRY_W      = MAT_FRAC + 2;
   localparam int CORDIC_STEPS = 32;
   localparam int STEP_W       = 5;
   localparam int CSR_INDEX_W  = 2;
   localparam int NUM_OPS      = 17;
   localparam int OP_W         = 5;
   localparam int NUM_ENTRIES  = 9;

   typedef logic signed [ENTRY_W-1:0] entry_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_TWIST = 2'd0,
      REG_LEAN  = 2'd1,
      REG_SWING = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      SRC_C1, SRC_S1, SRC_C2, SRC_S2, SRC_C3, SRC_S3, SRC_ONE, SRC_TMP
   } src_type;

   typedef enum logic [2:0] {
      ACC_SET, ACC_NEG, ACC_ADD, ACC_SUB, ACC_TMP
   } acc_type;

   typedef struct packed {
      src_type    a;
      src_type    b;
      logic       third;
      acc_type    acc;
      logic       wr;
      logic [3:0] idx;
   } op_type;

   typedef enum logic [2:0] {
      CS_START, CS_TRIG, CS_MUL, CS_ACC, CS_DONE
   } coef_state_type;

   // arctangent of 2^-i in 2^-32 turn units
   function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
      logic [31:0] v;
      case (i)
         5'd0:    v = 32'h20000000;
         5'd1:    v = 32'h12E4051E;
         5'd2:    v = 32'h09FB385B;
         5'd3:    v = 32'h051111D4;
         5'd4:    v = 32'h028B0D43;
         5'd5:    v = 32'h0145D7E1;
         5'd6:    v = 32'h00A2F61E;
         5'd7:    v = 32'h00517C55;
         5'd8:    v = 32'h0028BE53;
         5'd9:    v = 32'h00145F2F;
         5'd10:   v = 32'h000A2F98;
         5'd11:   v = 32'h000517CC;
         5'd12:   v = 32'h00028BE6;
         5'd13:   v = 32'h000145F3;
         5'd14:   v = 32'h0000A2FA;
         5'd15:   v = 32'h0000517D;
         5'd16:   v = 32'h000028BE;
         5'd17:   v = 32'h0000145F;
         5'd18:   v = 32'h00000A30;
         5'd19:   v = 32'h00000518;
         5'd20:   v = 32'h0000028C;
         5'd21:   v = 32'h00000146;
         5'd22:   v = 32'h000000A3;
         5'd23:   v = 32'h00000051;
         5'd24:   v = 32'h00000029;
         5'd25:   v = 32'h00000014;
         5'd26:   v = 32'h0000000A;
         5'd27:   v = 32'h00000005;
         5'd28:   v = 32'h00000003;
         5'd29:   v = 32'h00000001;
         5'd30:   v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

   function automatic op_type mk_op(input src_type a, input src_type b, input logic third,
                                    input acc_type acc, input logic wr, input logic [3:0] idx);
      op_type o;
      o.a     = a;
      o.b     = b;
      o.third = third;
      o.acc   = acc;
      o.wr    = wr;
      o.idx   = idx;
      return o;
   endfunction

   // matrix build sequence: one product per op, TMP holds the inner product of a triple
   function automatic op_type op_at(input logic [OP_W-1:0] n);
      op_type o;
      case (n)
         5'd0:    o = mk_op(SRC_C2,  SRC_ONE, 1'b0, ACC_SET, 1'b1, 4'd0);
         5'd1:    o = mk_op(SRC_S2,  SRC_S1,  1'b0, ACC_SET, 1'b1, 4'd1);
         5'd2:    o = mk_op(SRC_S2,  SRC_C1,  1'b0, ACC_SET, 1'b1, 4'd2);
         5'd3:    o = mk_op(SRC_S2,  SRC_S3,  1'b0, ACC_SET, 1'b1, 4'd3);
         5'd4:    o = mk_op(SRC_C1,  SRC_C3,  1'b0, ACC_SET, 1'b0, 4'd0);
         5'd5:    o = mk_op(SRC_C2,  SRC_S1,  1'b0, ACC_TMP, 1'b0, 4'd0);
         5'd6:    o = mk_op(SRC_TMP, SRC_S3,  1'b1, ACC_SUB, 1'b1, 4'd4);
         5'd7:    o = mk_op(SRC_C3,  SRC_S1,  1'b0, ACC_NEG, 1'b0, 4'd0);
         5'd8:    o = mk_op(SRC_C2,  SRC_C1,  1'b0, ACC_TMP, 1'b0, 4'd0);
         5'd9:    o = mk_op(SRC_TMP, SRC_S3,  1'b1, ACC_SUB, 1'b1, 4'd5);
         5'd10:   o = mk_op(SRC_S2,  SRC_C3,  1'b0, ACC_NEG, 1'b1, 4'd6);
         5'd11:   o = mk_op(SRC_C1,  SRC_S3,  1'b0, ACC_SET, 1'b0, 4'd0);
         5'd12:   o = mk_op(SRC_C2,  SRC_C3,  1'b0, ACC_TMP, 1'b0, 4'd0);
         5'd13:   o = mk_op(SRC_TMP, SRC_S1,  1'b1, ACC_ADD, 1'b1, 4'd7);
         5'd14:   o = mk_op(SRC_S1,  SRC_S3,  1'b0, ACC_NEG, 1'b0, 4'd0);
         5'd15:   o = mk_op(SRC_C2,  SRC_C1,  1'b0, ACC_TMP, 1'b0, 4'd0);
         5'd16:   o = mk_op(SRC_TMP, SRC_C3,  1'b1, ACC_ADD, 1'b1, 4'd8);
         default: o = mk_op(SRC_ONE, SRC_ONE, 1'b0, ACC_TMP, 1'b0, 4'd0);
      endcase
      return o;
   endfunction

endpackage

// File: hdl/euler_point_rotator.sv
// Top level of the Euler point rotator: angle registers, matrix builder and point pipeline.
//
// Rotates one signed 3D point per clock while req_stall is low, by the matrix built
// from the twist, lean and swing angles (twist first, then lean, then swing). The point
// path is a four-stage pipeline: a point may enter in any unstalled cycle, and rsp_valid
// for it rises once it reaches the result register, a stall on the result side holding
// all stages. The matrix is built by one shared CORDIC unit (32 steps per angle, three
// angles) followed by a single multiplier that runs seventeen multiply-accumulate
// ops; req_stall stays high after reset and after every angle write until the matrix
// is built. Each output component is truncated toward zero and saturated.
module euler_point_rotator #(
   parameter int COORD_WIDTH    = epr_pkg::COORD_WIDTH_DEF,
   parameter int ANGLE_WIDTH    = epr_pkg::ANGLE_WIDTH_DEF,
   parameter int TRIG_FRAC_BITS = epr_pkg::TRIG_FRAC_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [epr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ANGLE_WIDTH-1:0]          csr_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [COORD_WIDTH-1:0]   req_in_x,
   input  logic signed [COORD_WIDTH-1:0]   req_in_y,
   input  logic signed [COORD_WIDTH-1:0]   req_in_z,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [COORD_WIDTH:0]     rsp_out_x,
   output logic signed [COORD_WIDTH:0]     rsp_out_y,
   output logic signed [COORD_WIDTH:0]     rsp_out_z
);

   epr_pkg::entry_type mat [epr_pkg::NUM_ENTRIES];
   logic               mat_ready, pipe_stall;

   epr_coef #(
      .ANGLE_WIDTH   (ANGLE_WIDTH),
      .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
   ) u_coef (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .mat      (mat),
      .ready    (mat_ready)
   );

   epr_pipe #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_pipe (
      .clock    (clock),
      .reset    (reset),
      .mat      (mat),
      .in_valid (req_valid && mat_ready),
      .in_stall (pipe_stall),
      .in_x     (req_in_x),
      .in_y     (req_in_y),
      .in_z     (req_in_z),
      .out_valid(rsp_valid),
      .out_stall(rsp_stall),
      .out_x    (rsp_out_x),
      .out_y    (rsp_out_y),
      .out_z    (rsp_out_z)
   );

   assign req_stall = pipe_stall || !mat_ready;

endmodule

// File: hdl/epr_cordic.sv
// Iterative rotation-mode CORDIC: sine and cosine of a binary angle, one step per cycle.
module epr_cordic #(
   parameter int ANGLE_WIDTH    = epr_pkg::ANGLE_WIDTH_DEF,
   parameter int TRIG_FRAC_BITS = epr_pkg::TRIG_FRAC_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ANGLE_WIDTH-1:0]        angle,
   output logic                          done,
   output logic signed [TRIG_FRAC_BITS+1:0] cos_val,
   output logic signed [TRIG_FRAC_BITS+1:0] sin_val
);

   localparam int XW = TRIG_FRAC_BITS + 3;
   localparam int TW = TRIG_FRAC_BITS + 2;
   localparam int ZW = 33;
   localparam logic [63:0] X0_64 =
      (64'h9B74EDA8 + (64'd1 << (31 - TRIG_FRAC_BITS))) >> (32 - TRIG_FRAC_BITS);
   localparam logic signed [XW-1:0] X0    = XW'(X0_64);
   localparam logic signed [XW-1:0] ONE_X = XW'(64'd1 << TRIG_FRAC_BITS);

   logic signed [XW-1:0]       x_ff, x_in, y_ff, y_in, dx, dy, xc, yc;
   logic signed [ZW-1:0]       z_ff, z_in, at;
   logic [epr_pkg::STEP_W-1:0] cnt_ff;
   logic                       busy_ff, done_ff;
   logic [1:0]                 quad_ff;
   logic [31:0]                turn;

   assign turn = {angle, (32 - ANGLE_WIDTH)'(0)};
   assign dx   = y_ff >>> cnt_ff;
   assign dy   = x_ff >>> cnt_ff;
   assign at   = signed'({1'b0, epr_pkg::atan_turn(cnt_ff)});

   always_comb begin
      if (z_ff >= 0) begin
         x_in = x_ff - dx;
         y_in = y_ff + dy;
         z_in = z_ff - at;
      end else begin
         x_in = x_ff + dx;
         y_in = y_ff - dy;
         z_in = z_ff + at;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == epr_pkg::STEP_W'(epr_pkg::CORDIC_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff    <= X0;
         y_ff    <= '0;
         z_ff    <= signed'({3'b000, turn[29:0]});
         quad_ff <= turn[31:30];
      end else if (busy_ff) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   always_comb begin
      xc = (x_ff > ONE_X) ? ONE_X : ((x_ff < -ONE_X) ? -ONE_X : x_ff);
      yc = (y_ff > ONE_X) ? ONE_X : ((y_ff < -ONE_X) ? -ONE_X : y_ff);
      case (quad_ff)
         2'd0: begin
            cos_val = xc[TW-1:0];
            sin_val = yc[TW-1:0];
         end
         2'd1: begin
            cos_val = -yc[TW-1:0];
            sin_val = xc[TW-1:0];
         end
         2'd2: begin
            cos_val = -xc[TW-1:0];
            sin_val = -yc[TW-1:0];
         end
         default: begin
            cos_val = yc[TW-1:0];
            sin_val = -xc[TW-1:0];
         end
      endcase
   end

   assign done = done_ff;

endmodule

// File: hdl/epr_coef.sv
// Angle registers and the sequencer that builds the rotation matrix from them.
module epr_coef #(
   parameter int ANGLE_WIDTH    = epr_pkg::ANGLE_WIDTH_DEF,
   parameter int TRIG_FRAC_BITS = epr_pkg::TRIG_FRAC_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [epr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ANGLE_WIDTH-1:0]          csr_data,
   output epr_pkg::entry_type              mat [epr_pkg::NUM_ENTRIES],
   output logic                            ready
);

   localparam int F   = TRIG_FRAC_BITS;
   localparam int TW  = F + 2;
   localparam int EW  = epr_pkg::ENTRY_W;
   localparam int AW  = EW + 1;
   localparam int PW  = EW + TW;
   localparam int M   = epr_pkg::MAT_FRAC;
   localparam int SH2 = (2 * F > M) ? (2 * F - M) : 0;
   localparam int LS2 = (2 * F > M) ? 0 : (M - 2 * F);
   localparam logic signed [PW-1:0] RND2 = (SH2 > 0) ? PW'(64'd1 << (SH2 - 1)) : PW'(0);
   localparam logic signed [PW-1:0] RND3 = PW'(64'd1 << (F - 1));
   localparam logic signed [TW-1:0] ONE_T = TW'(64'd1 << F);
   localparam logic signed [AW-1:0] LIM   = AW'(64'd1 << M);

   epr_pkg::coef_state_type state_ff, state_in;

   logic [ANGLE_WIDTH-1:0]  twist_ff, lean_ff, swing_ff, trig_angle;
   logic [1:0]              trig_idx_ff;
   logic [epr_pkg::OP_W-1:0] op_ff;
   logic                    trig_start, trig_done;
   logic signed [TW-1:0]    trig_cos, trig_sin;
   logic signed [TW-1:0]    c1_ff, s1_ff, c2_ff, s2_ff, c3_ff, s3_ff, b_op;
   logic signed [EW-1:0]    a_op, tmp_ff, r;
   logic signed [PW-1:0]    prod_ff, r_full;
   logic signed [AW-1:0]    acc_ff, acc_in, r_ext;
   epr_pkg::entry_type      mat_ff [epr_pkg::NUM_ENTRIES];
   epr_pkg::op_type         op;

   epr_cordic #(
      .ANGLE_WIDTH   (ANGLE_WIDTH),
      .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
   ) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (trig_start),
      .angle  (trig_angle),
      .done   (trig_done),
      .cos_val(trig_cos),
      .sin_val(trig_sin)
   );

   assign op = epr_pkg::op_at(op_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         epr_pkg::CS_START: state_in = epr_pkg::CS_TRIG;
         epr_pkg::CS_TRIG: begin
            if (trig_done) begin
               state_in = (trig_idx_ff == 2'd2) ? epr_pkg::CS_MUL : epr_pkg::CS_START;
            end
         end
         epr_pkg::CS_MUL: state_in = epr_pkg::CS_ACC;
         epr_pkg::CS_ACC: begin
            if (op_ff == epr_pkg::OP_W'(epr_pkg::NUM_OPS - 1)) begin
               state_in = epr_pkg::CS_DONE;
            end else begin
               state_in = epr_pkg::CS_MUL;
            end
         end
         epr_pkg::CS_DONE: state_in = epr_pkg::CS_DONE;
         default:          state_in = epr_pkg::CS_START;
      endcase
      if (csr_we) begin
         state_in = epr_pkg::CS_START;
      end
   end

   // outputs of the sequencer
   always_comb begin
      trig_start = 1'b0;
      ready      = 1'b0;
      case (state_ff)
         epr_pkg::CS_START: trig_start = 1'b1;
         epr_pkg::CS_DONE:  ready      = 1'b1;
         default: begin
            trig_start = 1'b0;
            ready      = 1'b0;
         end
      endcase
   end

   always_comb begin
      case (trig_idx_ff)
         2'd0:    trig_angle = twist_ff;
         2'd1:    trig_angle = lean_ff;
         default: trig_angle = swing_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= epr_pkg::CS_START;
         trig_idx_ff <= '0;
         op_ff       <= '0;
         twist_ff    <= '0;
         lean_ff     <= '0;
         swing_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            trig_idx_ff <= '0;
            case (csr_index)
               epr_pkg::REG_TWIST: twist_ff <= csr_data;
               epr_pkg::REG_LEAN:  lean_ff  <= csr_data;
               epr_pkg::REG_SWING: swing_ff <= csr_data;
               default: ;
            endcase
         end else if (state_ff == epr_pkg::CS_TRIG && trig_done) begin
            trig_idx_ff <= trig_idx_ff + 1'b1;
         end
         if (state_ff == epr_pkg::CS_ACC) begin
            op_ff <= op_ff + 1'b1;
         end else if (state_ff != epr_pkg::CS_MUL) begin
            op_ff <= '0;
         end
      end
   end

   // operand selection
   always_comb begin
      case (op.a)
         epr_pkg::SRC_C1:  a_op = EW'(c1_ff);
         epr_pkg::SRC_S1:  a_op = EW'(s1_ff);
         epr_pkg::SRC_C2:  a_op = EW'(c2_ff);
         epr_pkg::SRC_S2:  a_op = EW'(s2_ff);
         epr_pkg::SRC_C3:  a_op = EW'(c3_ff);
         epr_pkg::SRC_S3:  a_op = EW'(s3_ff);
         epr_pkg::SRC_TMP: a_op = tmp_ff;
         default:          a_op = EW'(ONE_T);
      endcase
      case (op.b)
         epr_pkg::SRC_C1: b_op = c1_ff;
         epr_pkg::SRC_S1: b_op = s1_ff;
         epr_pkg::SRC_C2: b_op = c2_ff;
         epr_pkg::SRC_S2: b_op = s2_ff;
         epr_pkg::SRC_C3: b_op = c3_ff;
         epr_pkg::SRC_S3: b_op = s3_ff;
         default:         b_op = ONE_T;
      endcase
   end

   // rescale to matrix format, rounding half up
   always_comb begin
      if (op.third) begin
         r_full = (prod_ff + RND3) >>> F;
      end else begin
         r_full = ((prod_ff + RND2) >>> SH2) <<< LS2;
      end
      r     = r_full[EW-1:0];
      r_ext = AW'(r);
      case (op.acc)
         epr_pkg::ACC_SET: acc_in = r_ext;
         epr_pkg::ACC_NEG: acc_in = -r_ext;
         epr_pkg::ACC_ADD: acc_in = acc_ff + r_ext;
         epr_pkg::ACC_SUB: acc_in = acc_ff - r_ext;
         default:          acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == epr_pkg::CS_TRIG && trig_done) begin
         case (trig_idx_ff)
            2'd0: begin
               c1_ff <= trig_cos;
               s1_ff <= trig_sin;
            end
            2'd1: begin
               c2_ff <= trig_cos;
               s2_ff <= trig_sin;
            end
            default: begin
               c3_ff <= trig_cos;
               s3_ff <= trig_sin;
            end
         endcase
      end
      if (state_ff == epr_pkg::CS_MUL) begin
         prod_ff <= PW'(a_op) * PW'(b_op);
      end
      if (state_ff == epr_pkg::CS_ACC) begin
         if (op.acc == epr_pkg::ACC_TMP) begin
            tmp_ff <= r;
         end else begin
            acc_ff <= acc_in;
            if (op.wr) begin
               mat_ff[op.idx] <= (acc_in > LIM) ? EW'(LIM) :
                                 ((acc_in < -LIM) ? EW'(-LIM) : acc_in[EW-1:0]);
            end
         end
      end
   end

   assign mat = mat_ff;

   a_cfg_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !ready)
      else $error("matrix reported ready right after an angle write");

   a_mul_then_acc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == epr_pkg::CS_MUL && !csr_we) |=> state_ff == epr_pkg::CS_ACC)
      else $error("product not accumulated after multiply");

endmodule

// File: hdl/epr_pipe.sv
// Four-stage datapath: register point, nine products, row sums, truncate and saturate.
module epr_pipe #(
   parameter int COORD_WIDTH = epr_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  epr_pkg::entry_type            mat [epr_pkg::NUM_ENTRIES],
   input  logic                          in_valid,
   output logic                          in_stall,
   input  logic signed [COORD_WIDTH-1:0] in_x,
   input  logic signed [COORD_WIDTH-1:0] in_y,
   input  logic signed [COORD_WIDTH-1:0] in_z,
   output logic                          out_valid,
   input  logic                          out_stall,
   output logic signed [COORD_WIDTH:0]   out_x,
   output logic signed [COORD_WIDTH:0]   out_y,
   output logic signed [COORD_WIDTH:0]   out_z
);

   localparam int OW  = COORD_WIDTH + 1;
   localparam int PRW = epr_pkg::ENTRY_W + COORD_WIDTH;
   localparam int SW  = PRW + 2;
   localparam int M   = epr_pkg::MAT_FRAC;
   localparam logic signed [SW-1:0] RB   = SW'((64'd1 << M) - 1);
   localparam logic signed [SW-1:0] OMAX = SW'((64'd1 << COORD_WIDTH) - 1);
   localparam logic signed [SW-1:0] OMIN = -OMAX - SW'(1);

   logic                          ce;
   logic                          v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [COORD_WIDTH-1:0] p_ff [3];
   logic signed [PRW-1:0]         prod_ff [epr_pkg::NUM_ENTRIES];
   logic signed [SW-1:0]          sum_ff [3];
   logic signed [SW-1:0]          adj [3];
   logic signed [SW-1:0]          q [3];
   logic signed [OW-1:0]          res_in [3];
   logic signed [OW-1:0]          res_ff [3];

   // whole pipe holds while the result register is stalled
   assign ce       = !(v4_ff && out_stall);
   assign in_stall = !ce;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (ce) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         adj[r] = sum_ff[r] + ((sum_ff[r] < 0) ? RB : SW'(0));
         q[r]   = adj[r] >>> M;
         if (q[r] > OMAX) begin
            res_in[r] = OMAX[OW-1:0];
         end else if (q[r] < OMIN) begin
            res_in[r] = OMIN[OW-1:0];
         end else begin
            res_in[r] = q[r][OW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         p_ff[0] <= in_x;
         p_ff[1] <= in_y;
         p_ff[2] <= in_z;
         for (int e = 0; e < epr_pkg::NUM_ENTRIES; e++) begin
            prod_ff[e] <= PRW'(mat[e]) * PRW'(p_ff[e % 3]);
         end
         for (int r = 0; r < 3; r++) begin
            sum_ff[r] <= SW'(prod_ff[3 * r]) + SW'(prod_ff[3 * r + 1]) +
                         SW'(prod_ff[3 * r + 2]);
         end
         res_ff <= res_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_x     = res_ff[0];
   assign out_y     = res_ff[1];
   assign out_z     = res_ff[2];

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (in_valid && !in_stall) |=> v1_ff)
      else $error("accepted transaction missing from first stage");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && out_stall) |=> ($stable(v3_ff) && $stable(v2_ff)))
      else $error("inner stage moved while output stalled");

endmodule
